// ----- hdl/obgp_pkg.sv -----
// Shared types, register indexes and reset values of the box ground placement block.
`default_nettype none
package obgp_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int RESULT_WIDTH_DEF = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_VALID = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOL       = 4'd7;

  localparam logic [63:0] ROT_RESET   = 64'h4000_0000_0000_0000;
  localparam logic [47:0] SCALE_RESET = 48'h1000_1000_1000;
  localparam logic [13:0] TOL_RESET   = 14'd164;

  typedef struct packed {
    logic [47:0] box_min;
    logic [47:0] box_max;
    logic        box_valid;
    logic [47:0] trans;
    logic [63:0] rot;
    logic [47:0] scale;
    logic [15:0] clearance;
    logic [13:0] tol;
  } cfg_regs_t;

endpackage
`default_nettype wire

// ----- hdl/obgp_if.sv -----
// Valid/ready channel interfaces for queries, results and register writes.
`default_nettype none
interface obgp_item_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] impact_x;
  logic signed [CW-1:0] impact_y;
  logic signed [CW-1:0] impact_z;
  logic signed [15:0]   normal_x;
  logic signed [15:0]   normal_y;
  logic signed [15:0]   normal_z;
  modport source (output valid, impact_x, impact_y, impact_z, normal_x, normal_y,
                  normal_z, input ready);
  modport sink (input valid, impact_x, impact_y, impact_z, normal_x, normal_y,
                normal_z, output ready);
endinterface

interface obgp_result_if #(
  parameter int RW = 24
);
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic signed [RW-1:0] root_x;
  logic signed [RW-1:0] root_y;
  logic signed [RW-1:0] root_z;
  modport source (output valid, ok, root_x, root_y, root_z, input ready);
  modport sink (input valid, ok, root_x, root_y, root_z, output ready);
endinterface

interface obgp_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [obgp_pkg::CFG_IDX_W-1:0]        index;
  logic [obgp_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/obgp_cfg_regs.sv -----
// Configuration register file with its write decoder.
`default_nettype none
module obgp_cfg_regs (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  obgp_cfg_if.sink             cfg_i,
  output obgp_pkg::cfg_regs_t  regs_o
);

  obgp_pkg::cfg_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        obgp_pkg::REG_BOX_MIN:   regs_d.box_min   = cfg_i.data[47:0];
        obgp_pkg::REG_BOX_MAX:   regs_d.box_max   = cfg_i.data[47:0];
        obgp_pkg::REG_BOX_VALID: regs_d.box_valid = cfg_i.data[0];
        obgp_pkg::REG_TRANS:     regs_d.trans     = cfg_i.data[47:0];
        obgp_pkg::REG_ROT:       regs_d.rot       = cfg_i.data[63:0];
        obgp_pkg::REG_SCALE:     regs_d.scale     = cfg_i.data[47:0];
        obgp_pkg::REG_CLEARANCE: regs_d.clearance = cfg_i.data[15:0];
        obgp_pkg::REG_TOL:       regs_d.tol       = cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q           <= '0;
      regs_q.rot       <= obgp_pkg::ROT_RESET;
      regs_q.scale     <= obgp_pkg::SCALE_RESET;
      regs_q.tol       <= obgp_pkg::TOL_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/obgp_corner.sv -----
// Three-stage transform of one box corner and its projection on the normal.
`default_nettype none
module obgp_corner #(
  parameter int COORD_WIDTH = obgp_pkg::COORD_WIDTH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire signed [COORD_WIDTH+3:0]         v_i [3],
  input  wire signed [15:0]                    q_i [3],
  input  wire signed [15:0]                    w_i,
  input  wire signed [COORD_WIDTH-1:0]         tr_i [3],
  input  wire signed [15:0]                    n_i [3],
  output logic signed [COORD_WIDTH+COORD_WIDTH-COORD_WIDTH+4+5+6+18-1:0] proj_o
);

  localparam int VW  = COORD_WIDTH + 4;
  localparam int CRW = VW + 17;
  localparam int TW  = VW + 5;
  localparam int ERW = TW + 17;
  localparam int SW  = TW + 19;
  localparam int PW  = TW + 6;
  localparam int PJW = PW + 18;

  logic signed [CRW-1:0] c [3];
  logic signed [CRW+1:0] t2 [3];
  logic signed [CRW+1:0] tsh [3];
  logic signed [TW-1:0]  t_d [3];
  logic signed [TW-1:0]  t_q [3];
  logic signed [VW-1:0]  v_q [3];
  logic signed [ERW-1:0] e [3];
  logic signed [SW-1:0]  s [3];
  logic signed [SW-1:0]  ssh [3];
  logic signed [PW-1:0]  pr [3];
  logic signed [PW-1:0]  p_d [3];
  logic signed [PW-1:0]  p_q [3];
  logic signed [PJW-1:0] proj_d;

  // Half of the rotation: t = 2 * (q x v), rounded to Q.4.
  always_comb begin
    c[0] = q_i[1] * v_i[2] - q_i[2] * v_i[1];
    c[1] = q_i[2] * v_i[0] - q_i[0] * v_i[2];
    c[2] = q_i[0] * v_i[1] - q_i[1] * v_i[0];
    for (int a = 0; a < 3; a++) begin
      t2[a]  = (c[a] <<< 1) + 8192;
      tsh[a] = t2[a] >>> 14;
      t_d[a] = tsh[a][TW-1:0];
    end
  end

  // Second half: p = v + w*t + q x t, then translation.
  always_comb begin
    e[0] = q_i[1] * t_q[2] - q_i[2] * t_q[1];
    e[1] = q_i[2] * t_q[0] - q_i[0] * t_q[2];
    e[2] = q_i[0] * t_q[1] - q_i[1] * t_q[0];
    for (int a = 0; a < 3; a++) begin
      s[a]   = (v_q[a] <<< 14) + w_i * t_q[a] + e[a] + 8192;
      ssh[a] = s[a] >>> 14;
      pr[a]  = ssh[a][PW-1:0];
      p_d[a] = pr[a] + tr_i[a];
    end
  end

  assign proj_d = p_q[0] * n_i[0] + p_q[1] * n_i[1] + p_q[2] * n_i[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      v_q    <= v_i;
      p_q    <= p_d;
      proj_o <= proj_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/oriented_box_ground_placement.sv -----
// Top level of the oriented box ground placement pipeline.
//
//  channel   | dir | word                                  | accepted when
//  item_i    | in  | impact x/y/z, normal x/y/z            | valid && ready
//  result_o  | out | ok, root x/y/z                        | valid && ready
//  cfg_i     | in  | register index, 64-bit write data     | valid && ready (always ready)
//
// The datapath is a seven-stage pipeline with one word entering every cycle:
// scale and checks, first cross product, second cross product, projection,
// minimum over the eight corners, clearance offset, root and range check.
// That rate holds only while the result side does not stall the pipe.
// A stall on the result side freezes every stage at once, so nothing is lost
// or repeated; the input is ready whenever the output register is empty or
// being emptied. Reset clears the valid bits and loads the register defaults.
`default_nettype none
module oriented_box_ground_placement #(
  parameter int COORD_WIDTH  = obgp_pkg::COORD_WIDTH_DEF,
  parameter int RESULT_WIDTH = obgp_pkg::RESULT_WIDTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  obgp_item_if.sink    item_i,
  obgp_result_if.source result_o,
  obgp_cfg_if.sink     cfg_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int VW  = CW + 4;
  localparam int TW  = VW + 5;
  localparam int PW  = TW + 6;
  localparam int PJW = PW + 18;
  localparam int DW  = PJW - 12;
  localparam int XW  = ((DW + 3 > RESULT_WIDTH) ? DW + 3 : RESULT_WIDTH) + 1;
  localparam int NST = 7;

  obgp_pkg::cfg_regs_t regs;

  obgp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Field decode. The user must change configuration only while the pipe is empty
  // (the block does not enforce this), so every stage may read it directly.
  logic [95:0]           bmin_ext, bmax_ext, tr_ext;
  logic [47:0]           clr_ext;
  logic signed [CW-1:0]  bmin [3];
  logic signed [CW-1:0]  bmax [3];
  logic signed [CW-1:0]  tr [3];
  logic signed [15:0]    sc [3];
  logic signed [15:0]    q [3];
  logic signed [15:0]    w;
  logic signed [CW-1:0]  clr;

  assign bmin_ext = {48'b0, regs.box_min};
  assign bmax_ext = {48'b0, regs.box_max};
  assign tr_ext   = {48'b0, regs.trans};
  assign clr_ext  = {32'b0, regs.clearance};
  assign clr      = clr_ext[CW-1:0];
  assign w        = regs.rot[63:48];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      bmin[a] = bmin_ext[a*CW +: CW];
      bmax[a] = bmax_ext[a*CW +: CW];
      tr[a]   = tr_ext[a*CW +: CW];
      sc[a]   = regs.scale[a*16 +: 16];
      q[a]    = regs.rot[a*16 +: 16];
    end
  end

  // Global stall.
  logic            en;
  logic [NST:1]    valid_q;

  assign en           = !valid_q[NST] || result_o.ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NST-1:1], item_i.valid};
    end
  end

  // Stage 1: scaled bounds and the validity checks.
  logic signed [15:0]    n_in [3];
  logic signed [CW-1:0]  imp_in [3];
  logic signed [CW+16:0] prmin [3];
  logic signed [CW+16:0] prmax [3];
  logic signed [CW+16:0] shmin [3];
  logic signed [CW+16:0] shmax [3];
  logic signed [VW-1:0]  vmin_d [3];
  logic signed [VW-1:0]  vmax_d [3];
  logic signed [VW-1:0]  vmin_q [3];
  logic signed [VW-1:0]  vmax_q [3];
  logic signed [34:0]    qsum, nsum, qdev, ndev;
  logic [34:0]           qabs, nabs, tol_lim;
  logic                  ok_d;

  assign n_in[0]   = item_i.normal_x;
  assign n_in[1]   = item_i.normal_y;
  assign n_in[2]   = item_i.normal_z;
  assign imp_in[0] = item_i.impact_x;
  assign imp_in[1] = item_i.impact_y;
  assign imp_in[2] = item_i.impact_z;

  always_comb begin
    ok_d = regs.box_valid;
    for (int a = 0; a < 3; a++) begin
      prmin[a]  = bmin[a] * sc[a] + 2048;
      prmax[a]  = bmax[a] * sc[a] + 2048;
      shmin[a]  = prmin[a] >>> 12;
      shmax[a]  = prmax[a] >>> 12;
      vmin_d[a] = shmin[a][VW-1:0];
      vmax_d[a] = shmax[a][VW-1:0];
      if (bmin[a] > bmax[a]) ok_d = 1'b0;
    end
    qsum    = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + w * w;
    nsum    = n_in[0] * n_in[0] + n_in[1] * n_in[1] + n_in[2] * n_in[2];
    qdev    = qsum - 35'sd268435456;
    ndev    = nsum - 35'sd268435456;
    qabs    = qdev[34] ? 35'(-qdev) : 35'(qdev);
    nabs    = ndev[34] ? 35'(-ndev) : 35'(ndev);
    tol_lim = {7'b0, regs.tol, 14'b0};
    if (!(qabs < tol_lim)) ok_d = 1'b0;
    if (!(nabs < tol_lim)) ok_d = 1'b0;
    // A normal with every component within one LSB of zero has no direction.
    if (n_in[0] >= -16'sd1 && n_in[0] <= 16'sd1 && n_in[1] >= -16'sd1 &&
        n_in[1] <= 16'sd1 && n_in[2] >= -16'sd1 && n_in[2] <= 16'sd1) ok_d = 1'b0;
  end

  // Side pipe carrying the per-word data past the corner stages.
  logic                  ok_q  [1:NST-1];
  logic signed [15:0]    n_q   [1:NST-1][3];
  logic signed [CW-1:0]  imp_q [1:NST-1][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vmin_q   <= vmin_d;
      vmax_q   <= vmax_d;
      ok_q[1]  <= ok_d;
      n_q[1]   <= n_in;
      imp_q[1] <= imp_in;
      for (int s = 2; s < NST; s++) begin
        ok_q[s]  <= ok_q[s-1];
        n_q[s]   <= n_q[s-1];
        imp_q[s] <= imp_q[s-1];
      end
    end
  end

  // Stages 2 to 4: the eight corners in parallel.
  logic signed [PJW-1:0] proj [8];

  for (genvar k = 0; k < 8; k++) begin : g_corner
    logic signed [VW-1:0] v [3];
    for (genvar a = 0; a < 3; a++) begin : g_axis
      assign v[a] = (((k >> (2 - a)) & 1) != 0) ? vmax_q[a] : vmin_q[a];
    end
    obgp_corner #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_corner (
      .clk_i  (clk_i),
      .en_i   (en),
      .v_i    (v),
      .q_i    (q),
      .w_i    (w),
      .tr_i   (tr),
      .n_i    (n_q[3]),
      .proj_o (proj[k])
    );
  end

  // Stage 5: smallest projection, as a three-level compare tree.
  logic signed [PJW-1:0] m1 [4];
  logic signed [PJW-1:0] m2 [2];
  logic signed [PJW-1:0] min_d, min_q;

  always_comb begin
    for (int i = 0; i < 4; i++) m1[i] = (proj[2*i+1] < proj[2*i]) ? proj[2*i+1] : proj[2*i];
    for (int i = 0; i < 2; i++) m2[i] = (m1[2*i+1] < m1[2*i]) ? m1[2*i+1] : m1[2*i];
    min_d = (m2[1] < m2[0]) ? m2[1] : m2[0];
  end

  // Stage 6: distance to move along the normal.
  logic signed [PJW+1:0] dd, dsh;
  logic signed [DW-1:0]  d_d, d_q;

  always_comb begin
    dd  = (clr <<< 14) - min_q + 8192;
    dsh = dd >>> 14;
    d_d = dsh[DW-1:0];
  end

  // Stage 7: root location and range check.
  logic signed [DW+17:0] nd [3];
  logic signed [DW+17:0] ndsh [3];
  logic signed [DW+1:0]  ndr [3];
  logic signed [XW-1:0]  r [3];
  logic                  ok_out_d;
  logic signed [RESULT_WIDTH-1:0] root_d [3];
  logic signed [RESULT_WIDTH-1:0] root_q [3];
  logic                  ok_out_q;

  always_comb begin
    ok_out_d = ok_q[NST-1];
    for (int a = 0; a < 3; a++) begin
      nd[a]   = n_q[NST-1][a] * d_q + 8192;
      ndsh[a] = nd[a] >>> 14;
      ndr[a]  = ndsh[a][DW+1:0];
      r[a]    = imp_q[NST-1][a] + ndr[a];
      if (!((&r[a][XW-1:RESULT_WIDTH-1]) || !(|r[a][XW-1:RESULT_WIDTH-1]))) ok_out_d = 1'b0;
    end
    for (int a = 0; a < 3; a++) begin
      root_d[a] = ok_out_d ? r[a][RESULT_WIDTH-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      min_q    <= min_d;
      d_q      <= d_d;
      root_q   <= root_d;
      ok_out_q <= ok_out_d;
    end
  end

  assign result_o.valid  = valid_q[NST];
  assign result_o.ok     = ok_out_q;
  assign result_o.root_x = root_q[0];
  assign result_o.root_y = root_q[1];
  assign result_o.root_z = root_q[2];

endmodule
`default_nettype wire
